>>> design/chc_pkg.sv
// shared types and constants of the channel health checker
package chc_pkg;

    localparam int MAX_CHANNELS = 512;
    localparam int COUNT_W      = 32;
    localparam int ADDR_W       = $clog2(MAX_CHANNELS);
    localparam int N_W          = $clog2(MAX_CHANNELS + 1);
    localparam int TOT_W        = COUNT_W + ADDR_W;
    localparam int FACTOR_W     = 8;
    localparam int THR_W        = TOT_W + FACTOR_W;
    localparam int PROD_W       = COUNT_W + N_W;
    localparam int CMP_W        = 64;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LOW  = 3'd5;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } chc_kind_t;

    typedef struct packed {
        chc_kind_t    kind;
        logic [8:0]   channel;
        logic [31:0]  count;
        logic [31:0]  reference_count;
    } chc_cmd_t;

    typedef struct packed {
        logic [N_W-1:0] n;
        logic [31:0]    min_reference;
        logic [7:0]     noisy_factor;
        logic [9:0]     bad_channel_limit;
        logic [31:0]    rate_high_q16;
        logic [31:0]    rate_low_q16;
    } chc_cfg_t;

    typedef struct packed {
        logic init_busy;
    } chc_status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN1,
        ST_SUM,
        ST_SCAN2,
        ST_RATE1,
        ST_RATE2,
        ST_CLEAR,
        ST_DONE
    } chc_state_t;

    function automatic logic [9:0] sat10(input logic [N_W-1:0] v);
        logic [N_W+9:0] w;
        w = (N_W+10)'(v);
        return (w > (N_W+10)'(1023)) ? 10'd1023 : w[9:0];
    endfunction

endpackage

>>> design/chc_if.sv
// request and result channel interfaces
interface chc_item_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [8:0]  channel;
    logic [31:0] count;
    logic [31:0] reference_count;

    modport source (output valid, op, channel, count, reference_count, input ready);
    modport sink   (input valid, op, channel, count, reference_count, output ready);
endinterface

interface chc_result_if;
    logic        valid;
    logic        ready;
    logic        low_reference;
    logic        all_dead;
    logic        too_many_dead;
    logic        too_many_noisy;
    logic        wrong_rate;
    logic [9:0]  dead_count;
    logic [9:0]  noisy_count;
    logic [40:0] corrected_total;

    modport source (output valid, low_reference, all_dead, too_many_dead, too_many_noisy,
                    wrong_rate, dead_count, noisy_count, corrected_total, input ready);
    modport sink   (input valid, low_reference, all_dead, too_many_dead, too_many_noisy,
                    wrong_rate, dead_count, noisy_count, corrected_total, output ready);
endinterface

>>> design/chc_ram.sv
// generic single port ram with registered read
module chc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> design/chc_front.sv
// request intake, decode and command queue
module chc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    chc_item_if.sink             item,
    input  chc_pkg::chc_status_t status,
    output logic                 cmd_valid,
    output chc_pkg::chc_cmd_t    cmd,
    input  logic                 cmd_pop
);
    import chc_pkg::*;

    chc_cmd_t              fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   fill_reg, fill_next;
    logic                  push;
    logic                  pop;
    chc_cmd_t              entry;

    assign item.ready = (fill_reg != (FIFO_PTR_W+1)'(FIFO_DEPTH)) && !status.init_busy;
    assign push       = item.valid && item.ready;
    assign pop        = cmd_pop && cmd_valid;
    assign cmd_valid  = fill_reg != '0;
    assign cmd        = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        entry.kind            = item.op ? CMD_EVAL : CMD_LOAD;
        entry.channel         = item.channel;
        entry.count           = item.count;
        entry.reference_count = item.reference_count;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
    end
endmodule

>>> design/chc_back.sv
// command execution: store writes, channel scans, clearing and result register
module chc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  chc_pkg::chc_cfg_t    cfg,
    input  logic                 cmd_valid,
    input  chc_pkg::chc_cmd_t    cmd,
    output logic                 cmd_pop,
    output chc_pkg::chc_status_t status,
    chc_result_if.source         result
);
    import chc_pkg::*;

    chc_state_t state_reg, state_next;

    logic [N_W-1:0]     idx_reg;
    logic               v1_reg, v2_reg;
    logic               first_reg;
    logic [ADDR_W-1:0]  ram_addr;
    logic               ram_we;
    logic [COUNT_W-1:0] ram_wdata;
    logic [COUNT_W-1:0] ram_rdata;
    logic               issue;
    logic               scan_done;
    logic               clear_done;
    logic               res_free;

    logic [31:0]        ref_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [COUNT_W-1:0] min_reg, max_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [COUNT_W-1:0] c2_reg;
    logic               zero2_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic [N_W-1:0]     dead_reg, noisy_reg;
    logic [63:0]        hi_prod_reg, lo_prod_reg;
    logic               low_ref_reg, all_dead_reg, many_dead_reg, many_noisy_reg, wrong_reg;
    logic [CMP_W-1:0]   shifted;

    chc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_CHANNELS)) u_store (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign scan_done  = (idx_reg == cfg.n) && !v1_reg && !v2_reg;
    assign clear_done = idx_reg == N_W'(MAX_CHANNELS);
    assign res_free   = !result.valid || result.ready;
    assign shifted    = CMP_W'(total_reg) << 16;
    assign status.init_busy = state_reg == ST_INIT;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && cmd.kind == CMD_EVAL)
                begin
                    state_next = (cmd.reference_count < cfg.min_reference) ? ST_CLEAR : ST_SCAN1;
                end
            end
            ST_SCAN1:
            begin
                if (scan_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = (total_reg == '0) ? ST_CLEAR : ST_SCAN2;
            end
            ST_SCAN2:
            begin
                if (scan_done)
                begin
                    state_next = ST_RATE1;
                end
            end
            ST_RATE1:
            begin
                state_next = ST_RATE2;
            end
            ST_RATE2:
            begin
                state_next = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        ram_addr  = idx_reg[ADDR_W-1:0];
        ram_we    = 1'b0;
        ram_wdata = '0;
        cmd_pop   = 1'b0;
        issue     = 1'b0;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                ram_we = !clear_done;
            end
            ST_IDLE:
            begin
                cmd_pop = cmd_valid;
                if (cmd_valid && cmd.kind == CMD_LOAD)
                begin
                    ram_addr  = cmd.channel[ADDR_W-1:0];
                    ram_wdata = cmd.count[COUNT_W-1:0];
                    ram_we    = 32'(cmd.channel) < MAX_CHANNELS;
                end
            end
            ST_SCAN1, ST_SCAN2:
            begin
                issue = idx_reg != cfg.n;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            idx_reg      <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            result.valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg && state_reg == ST_SCAN2;
            if (state_next != state_reg)
            begin
                idx_reg <= '0;
            end
            else if (issue || ((state_reg == ST_INIT || state_reg == ST_CLEAR) && !clear_done))
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (state_reg == ST_DONE && res_free)
            begin
                result.valid <= 1'b1;
            end
            else if (result.ready)
            begin
                result.valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                ref_reg        <= cmd.reference_count;
                low_ref_reg    <= cmd.reference_count < cfg.min_reference;
                total_reg      <= '0;
                dead_reg       <= '0;
                noisy_reg      <= '0;
                first_reg      <= 1'b1;
                all_dead_reg   <= 1'b0;
                many_dead_reg  <= 1'b0;
                many_noisy_reg <= 1'b0;
                wrong_reg      <= 1'b0;
            end
            ST_SCAN1:
            begin
                if (v1_reg)
                begin
                    first_reg <= 1'b0;
                    total_reg <= total_reg + TOT_W'(ram_rdata);
                    if (first_reg || ram_rdata < min_reg)
                    begin
                        min_reg <= ram_rdata;
                    end
                    if (first_reg || ram_rdata > max_reg)
                    begin
                        max_reg <= ram_rdata;
                    end
                end
            end
            ST_SUM:
            begin
                thr_reg <= THR_W'(cfg.noisy_factor)
                         * THR_W'(total_reg - TOT_W'(min_reg) - TOT_W'(max_reg));
                if (total_reg == '0)
                begin
                    all_dead_reg <= 1'b1;
                    dead_reg     <= cfg.n;
                end
            end
            ST_SCAN2:
            begin
                if (v1_reg)
                begin
                    c2_reg    <= ram_rdata;
                    zero2_reg <= ram_rdata == '0;
                    prod2_reg <= PROD_W'(ram_rdata - 1'b1) * PROD_W'(cfg.n - 2'd2);
                end
                if (v2_reg)
                begin
                    if (zero2_reg)
                    begin
                        dead_reg <= dead_reg + 1'b1;
                    end
                    else if (CMP_W'(prod2_reg) > CMP_W'(thr_reg))
                    begin
                        noisy_reg <= noisy_reg + 1'b1;
                        total_reg <= total_reg - TOT_W'(c2_reg);
                    end
                end
            end
            ST_RATE1:
            begin
                hi_prod_reg <= 64'(cfg.rate_high_q16) * 64'(ref_reg);
                lo_prod_reg <= 64'(cfg.rate_low_q16) * 64'(ref_reg);
            end
            ST_RATE2:
            begin
                wrong_reg      <= shifted > hi_prod_reg || shifted < lo_prod_reg;
                many_dead_reg  <= (N_W+10)'(dead_reg) > (N_W+10)'(cfg.bad_channel_limit);
                many_noisy_reg <= (N_W+10)'(noisy_reg) > (N_W+10)'(cfg.bad_channel_limit);
            end
            default:
            begin
                c2_reg <= c2_reg;
            end
        endcase
        if (state_reg == ST_DONE && res_free)
        begin
            result.low_reference   <= low_ref_reg;
            result.all_dead        <= all_dead_reg;
            result.too_many_dead   <= many_dead_reg;
            result.too_many_noisy  <= many_noisy_reg;
            result.wrong_rate      <= wrong_reg;
            result.dead_count      <= sat10(dead_reg);
            result.noisy_count     <= sat10(noisy_reg);
            result.corrected_total <= (low_ref_reg || all_dead_reg) ? 41'd0 : 41'(total_reg);
        end
    end

`ifndef SYNTHESIS
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN1 || state_reg == ST_SCAN2) |-> !ram_we)
        else $error("store written during scan");
    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done");
    a_bad_within_n: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RATE1 |-> (N_W+1)'(dead_reg) + (N_W+1)'(noisy_reg) <= (N_W+1)'(cfg.n))
        else $error("dead plus noisy exceeds channels");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> state_reg == ST_IDLE)
        else $error("command taken while busy");
`endif
endmodule

>>> design/channel_health_checker.sv
// top level of the channel health checker
// Load requests write one channel count into a 512 entry store and are taken one per
// cycle while no evaluate runs and the queue has room. An evaluate request walks the
// store over the active channels n (sum, min and max) and, unless the sum is zero, a
// second time (dead and noisy classification), then sweeps all 512 entries to clear
// them through the single store port; a low reference request skips the walks.
// After reset a clearing sweep runs, during which no request is taken. A four entry
// command queue sits between intake and execution, and the result waits in an output
// register.
module channel_health_checker (
    input  logic        clk,
    input  logic        rst_n,
    chc_item_if.sink    item,
    chc_result_if.source result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import chc_pkg::*;

    logic [9:0]  channels_reg;
    logic [31:0] min_ref_reg;
    logic [7:0]  factor_reg;
    logic [9:0]  bad_limit_reg;
    logic [31:0] rate_high_reg;
    logic [31:0] rate_low_reg;

    chc_cfg_t    cfg;
    chc_status_t status;
    chc_cmd_t    cmd;
    logic        cmd_valid;
    logic        cmd_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg  <= 10'd512;
            min_ref_reg   <= 32'd100000;
            factor_reg    <= 8'd10;
            bad_limit_reg <= 10'd15;
            rate_high_reg <= 32'd6586;
            rate_low_reg  <= 32'd2195;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHANNELS:  channels_reg  <= cfg_data[9:0];
                CFG_MIN_REF:   min_ref_reg   <= cfg_data;
                CFG_FACTOR:    factor_reg    <= cfg_data[7:0];
                CFG_BAD_LIMIT: bad_limit_reg <= cfg_data[9:0];
                CFG_RATE_HIGH: rate_high_reg <= cfg_data;
                CFG_RATE_LOW:  rate_low_reg  <= cfg_data;
                default:       factor_reg    <= factor_reg;
            endcase
        end
    end

    always_comb
    begin
        if (32'(channels_reg) < 32'd3)
        begin
            cfg.n = N_W'(3);
        end
        else if (32'(channels_reg) > MAX_CHANNELS)
        begin
            cfg.n = N_W'(MAX_CHANNELS);
        end
        else
        begin
            cfg.n = N_W'(channels_reg);
        end
        cfg.min_reference     = min_ref_reg;
        cfg.noisy_factor      = factor_reg;
        cfg.bad_channel_limit = bad_limit_reg;
        cfg.rate_high_q16     = rate_high_reg;
        cfg.rate_low_q16      = rate_low_reg;
    end

    chc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .status    (status),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    chc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .status    (status),
        .result    (result)
    );
endmodule

>>> verif/chc_tb_if.sv
// result record type used by the testbench scoreboard
package chc_tb_pkg;

    typedef struct packed {
        logic        low_reference;
        logic        all_dead;
        logic        too_many_dead;
        logic        too_many_noisy;
        logic        wrong_rate;
        logic [9:0]  dead_count;
        logic [9:0]  noisy_count;
        logic [40:0] corrected_total;
    } verdict_t;

endpackage

>>> verif/tb_channel_health_checker.sv
// testbench of the channel health checker: random and directed requests, scoreboard check
module tb_channel_health_checker;
    timeunit 1ns;
    timeprecision 1ps;
    import chc_pkg::*;
    import chc_tb_pkg::*;

    class verdict_board;
        logic [31:0] counts [MAX_CHANNELS];
        int unsigned n_active = 512;
        logic [31:0] min_ref = 100000;
        logic [7:0]  factor = 10;
        logic [9:0]  bad_limit = 15;
        logic [31:0] rate_high = 6586;
        logic [31:0] rate_low = 2195;
        verdict_t    pending [$];
        int          errors = 0;

        function new();
            foreach (counts[i]) counts[i] = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                CFG_CHANNELS:  n_active = 32'(v[9:0]);
                CFG_MIN_REF:   min_ref = v;
                CFG_FACTOR:    factor = v[7:0];
                CFG_BAD_LIMIT: bad_limit = v[9:0];
                CFG_RATE_HIGH: rate_high = v;
                CFG_RATE_LOW:  rate_low = v;
                default: ;
            endcase
        endfunction

        function void note_request(chc_kind_t kind, logic [8:0] ch, logic [31:0] cnt,
                                   logic [31:0] ref_cnt);
            verdict_t v;
            int unsigned n, dead, noisy;
            logic [63:0] sum, lo, hi, thr, c, scaled;
            v = '0;
            if (kind == CMD_LOAD)
            begin
                counts[ch] = cnt;
                return;
            end
            n = n_active < 3 ? 3 : (n_active > MAX_CHANNELS ? MAX_CHANNELS : n_active);
            dead = 0;
            noisy = 0;
            if (ref_cnt < min_ref)
                v.low_reference = 1'b1;
            else
            begin
                sum = '0;
                lo = 64'(counts[0]);
                hi = 64'(counts[0]);
                for (int i = 0; i < n; i++)
                begin
                    c = 64'(counts[i]);
                    sum += c;
                    if (c < lo) lo = c;
                    if (c > hi) hi = c;
                end
                if (sum == 0)
                begin
                    v.all_dead = 1'b1;
                    v.dead_count = 10'(n > 1023 ? 1023 : n);
                end
                else
                begin
                    thr = 64'(factor) * (sum - lo - hi);
                    for (int i = 0; i < n; i++)
                    begin
                        c = 64'(counts[i]);
                        if (c == 0)
                            dead++;
                        else if ((c - 64'd1) * 64'(n - 2) > thr)
                        begin
                            noisy++;
                            sum -= c;
                        end
                    end
                    scaled = sum << 16;
                    v.too_many_dead = dead > 32'(bad_limit);
                    v.too_many_noisy = noisy > 32'(bad_limit);
                    v.wrong_rate = scaled > 64'(rate_high) * 64'(ref_cnt) ||
                                   scaled < 64'(rate_low) * 64'(ref_cnt);
                    v.dead_count = 10'(dead > 1023 ? 1023 : dead);
                    v.noisy_count = 10'(noisy > 1023 ? 1023 : noisy);
                    v.corrected_total = sum[40:0];
                end
            end
            foreach (counts[i]) counts[i] = '0;
            pending = {pending, v};
        endfunction

        function void report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %s: got %0d expected %0d", what, got, want);
        endfunction

        function void check_result(verdict_t got);
            verdict_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", 64'd1, 64'd0);
                return;
            end
            w = pending.pop_front();
            if (got.low_reference != w.low_reference)
                report("low_reference", got.low_reference, w.low_reference);
            if (got.all_dead != w.all_dead) report("all_dead", got.all_dead, w.all_dead);
            if (got.too_many_dead != w.too_many_dead)
                report("too_many_dead", got.too_many_dead, w.too_many_dead);
            if (got.too_many_noisy != w.too_many_noisy)
                report("too_many_noisy", got.too_many_noisy, w.too_many_noisy);
            if (got.wrong_rate != w.wrong_rate)
                report("wrong_rate", got.wrong_rate, w.wrong_rate);
            if (got.dead_count != w.dead_count)
                report("dead_count", got.dead_count, w.dead_count);
            if (got.noisy_count != w.noisy_count)
                report("noisy_count", got.noisy_count, w.noisy_count);
            if (got.corrected_total != w.corrected_total)
                report("corrected_total", got.corrected_total, w.corrected_total);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    bit          calm = 1'b0;
    verdict_board board;

    chc_item_if   item ();
    chc_result_if result ();

    channel_health_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item.sink),
        .result    (result.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        item.valid = 1'b0;
        item.op = 1'b0;
        item.channel = '0;
        item.count = '0;
        item.reference_count = '0;
        result.ready = 1'b0;
    end

    initial
    begin
        #60ms;
        $display("[channel_health_checker] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready)
                board.check_result({result.low_reference, result.all_dead,
                    result.too_many_dead, result.too_many_noisy, result.wrong_rate,
                    result.dead_count, result.noisy_count, result.corrected_total});
            result.ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    task automatic send(chc_kind_t kind, logic [8:0] ch, logic [31:0] cnt,
                        logic [31:0] ref_cnt);
        while (!calm && $urandom_range(99) < 7)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid <= 1'b1;
        item.op <= kind;
        item.channel <= ch;
        item.count <= cnt;
        item.reference_count <= ref_cnt;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        board.note_request(kind, ch, cnt, ref_cnt);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic drain();
        item.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_count(int kind);
        case (kind)
            0: return 32'd0;
            1: return $urandom_range(1, 50);
            2: return $urandom();
            default: return $urandom_range(900, 1100);
        endcase
    endfunction

    // one burst: random loads on channels 0 to n + 2 (at most 511), then an evaluate
    task automatic burst(int n, int style);
        int loads;
        loads = $urandom_range(0, 2 * n);
        for (int i = 0; i < loads; i++)
            send(CMD_LOAD, 9'($urandom_range(0, n + 2 > 511 ? 511 : n + 2)),
                 pick_count($urandom_range(99) < 10 ? 2 :
                     ($urandom_range(99) < 15 ? 0 : (style ? 3 : 1))), '0);
        send(CMD_EVAL, 9'($urandom()), $urandom(),
             $urandom_range(99) < 20 ? $urandom() : $urandom_range(0, 300));
    endtask

    initial
    begin
        int sent, n;
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, dead station, low reference, extremes of fields
        send(CMD_EVAL, '0, '0, 32'd99999);
        send(CMD_EVAL, 9'h1ff, 32'hffffffff, 32'hffffffff);
        send(CMD_LOAD, 9'd0, 32'hffffffff, '0);
        send(CMD_LOAD, 9'd511, 32'hffffffff, '0);
        send(CMD_LOAD, 9'd5, 32'd1, '0);
        send(CMD_EVAL, '0, '0, 32'hffffffff);
        drain();
        write_reg(CFG_CHANNELS, 32'd0);
        write_reg(CFG_MIN_REF, 32'd0);
        write_reg(CFG_FACTOR, 32'd1);
        write_reg(CFG_BAD_LIMIT, 32'd0);
        write_reg(CFG_RATE_HIGH, 32'hffffffff);
        write_reg(CFG_RATE_LOW, 32'd0);
        send(CMD_LOAD, 9'd0, 32'd7, '0);
        send(CMD_LOAD, 9'd1, 32'd1000, '0);
        send(CMD_LOAD, 9'd2, 32'hffffffff, '0);
        send(CMD_EVAL, '0, '0, 32'd0);
        send(CMD_LOAD, 9'd1, 32'd5, '0);
        send(CMD_EVAL, '0, '0, 32'd0);
        send(CMD_EVAL, '0, '0, 32'd0);
        drain();
        write_reg(CFG_CHANNELS, 32'h3ff);
        write_reg(CFG_FACTOR, 32'd255);
        write_reg(CFG_BAD_LIMIT, 32'd512);
        write_reg(CFG_RATE_HIGH, 32'd0);
        write_reg(CFG_RATE_LOW, 32'hffffffff);
        send(CMD_LOAD, 9'd100, 32'd12345, '0);
        send(CMD_EVAL, '0, '0, 32'd1);
        drain();

        sent = 0;
        for (int phase = 0; sent < 900; phase++)
        begin
            calm = (phase == 3);
            n = phase % 5 == 4 ? $urandom_range(3, 512) : $urandom_range(3, 24);
            write_reg(CFG_CHANNELS, phase % 7 == 6 ? $urandom_range(0, 1023) : n);
            write_reg(CFG_MIN_REF, $urandom_range(0, 250));
            write_reg(CFG_FACTOR, $urandom_range(1, 12));
            write_reg(CFG_BAD_LIMIT, $urandom_range(0, 6));
            write_reg(CFG_RATE_HIGH, $urandom_range(0, 99) < 10 ? $urandom()
                      : $urandom_range(65536, 65536 * 400));
            write_reg(CFG_RATE_LOW, $urandom_range(0, 65536 * 40));
            for (int b = 0; b < 4; b++)
            begin
                burst(n > 40 ? 8 : n, $urandom_range(1));
                sent += n > 40 ? 10 : n + 1;
            end
            drain();
        end
        calm = 1'b0;
        drain();
        if (board.errors == 0)
            $display("[channel_health_checker] OK");
        else
            $display("[channel_health_checker] ERROR");
        $finish;
    end
endmodule
